// ----- sv/trra_pkg.sv -----
// Package for the tensor roll address unit.
// Register index codes and fixed field widths; no dependencies.
`timescale 1ns / 1ps

package trra_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned SizeRegW = 16;
  localparam int unsigned ShiftW   = 17;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIZE0  = 4'd0,
    REG_SIZE1  = 4'd1,
    REG_SIZE2  = 4'd2,
    REG_SIZE3  = 4'd3,
    REG_SHIFT0 = 4'd4,
    REG_SHIFT1 = 4'd5,
    REG_SHIFT2 = 4'd6,
    REG_SHIFT3 = 4'd7
  } cfg_reg_e;

endpackage

// ----- sv/tensor_roll_address_4d_unit.sv -----
// Top level of the 4-D tensor roll address unit.
// Uses trra_pkg, trra_div_chain, trra_roll_cell and trra_mac_cell.
`timescale 1ns / 1ps

// Accepts one transaction per cycle (busy is always low) and returns each
// result with result_valid_o high for one cycle: three pipelined dividers
// of INDEX_BITS one-bit cells split the index, one stage rolls the four
// coordinates and three multiply-add stages build the address. The receiver
// cannot stall. Configuration is to be written only while no transaction is
// in flight; the block does not enforce this. A size of zero counts as one.

module tensor_roll_address_4d_unit
  import trra_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = 16,
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         element_index_i,
  input  logic [31:0]         data_word_i,
  output logic                result_valid_o,
  output logic [31:0]         dest_address_o,
  output logic [31:0]         data_out_o,
  output logic                range_error_o
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned SB = SIZE_BITS;
  localparam int unsigned CW = ((IB > ShiftW) ? IB : ShiftW) + 2;

  logic [SizeRegW-1:0] size_q  [4];
  logic [ShiftW-1:0]   shift_q [4];
  logic [SB-1:0]       sz      [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 4; a++) begin
        size_q[a]  <= SizeRegW'(1);
        shift_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SIZE0:  size_q[0]  <= cfg_wdata_i[SizeRegW-1:0];
        REG_SIZE1:  size_q[1]  <= cfg_wdata_i[SizeRegW-1:0];
        REG_SIZE2:  size_q[2]  <= cfg_wdata_i[SizeRegW-1:0];
        REG_SIZE3:  size_q[3]  <= cfg_wdata_i[SizeRegW-1:0];
        REG_SHIFT0: shift_q[0] <= cfg_wdata_i[ShiftW-1:0];
        REG_SHIFT1: shift_q[1] <= cfg_wdata_i[ShiftW-1:0];
        REG_SHIFT2: shift_q[2] <= cfg_wdata_i[ShiftW-1:0];
        REG_SHIFT3: shift_q[3] <= cfg_wdata_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      sz[a] = (size_q[a][SB-1:0] == '0) ? SB'(1) : size_q[a][SB-1:0];
    end
  end

  assign busy = 1'b0;

  // index split: c3, c2, c1 remainders, c0 final quotient
  logic          v1, v2, v3;
  logic [IB-1:0] q1, q2, q3;
  logic [SB-1:0] r1, r2, r3;
  logic [31:0]   s1;
  logic [32+SB-1:0]   s2;
  logic [32+2*SB-1:0] s3;

  trra_div_chain #(.IB(IB), .SB(SB), .SW(32)) u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .dividend_i (element_index_i[IB-1:0]),
    .side_i     (data_word_i),
    .divisor_i  (sz[3]),
    .valid_o    (v1),
    .quot_o     (q1),
    .rem_o      (r1),
    .side_o     (s1)
  );

  trra_div_chain #(.IB(IB), .SB(SB), .SW(32+SB)) u_div2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1),
    .dividend_i (q1),
    .side_i     ({s1, r1}),
    .divisor_i  (sz[2]),
    .valid_o    (v2),
    .quot_o     (q2),
    .rem_o      (r2),
    .side_o     (s2)
  );

  trra_div_chain #(.IB(IB), .SB(SB), .SW(32+2*SB)) u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v2),
    .dividend_i (q2),
    .side_i     ({s2, r2}),
    .divisor_i  (sz[1]),
    .valid_o    (v3),
    .quot_o     (q3),
    .rem_o      (r3),
    .side_o     (s3)
  );

  // roll stage
  logic [CW-1:0] c_in  [4];
  logic [CW-1:0] c_out [4];
  logic [3:0]    c_err;
  logic          rv_q;
  logic [31:0]   rdata_q;

  assign c_in[0] = CW'(q3);
  assign c_in[1] = CW'(r3);
  assign c_in[2] = CW'(s3[SB-1:0]);
  assign c_in[3] = CW'(s3[2*SB-1:SB]);

  for (genvar a = 0; a < 4; a++) begin : g_roll
    trra_roll_cell #(.CW(CW), .SB(SB)) u_roll (
      .clk_i   (clk_i),
      .coord_i (c_in[a]),
      .size_i  (sz[a]),
      .shift_i (shift_q[a]),
      .coord_o (c_out[a]),
      .err_o   (c_err[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= s3[32+2*SB-1:2*SB];
  end

  // address build
  localparam int unsigned M1W = 2*IB + 33;
  localparam int unsigned M2W = IB + 33;
  localparam int unsigned M3W = 33;

  logic           m1v, m2v, m3v;
  logic [IB-1:0]  a1, a2, a3;
  logic [M1W-1:0] m1s;
  logic [M2W-1:0] m2s;
  logic [M3W-1:0] m3s;

  trra_mac_cell #(.IB(IB), .SB(SB), .SW(M1W)) u_mac1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q),
    .acc_i   (c_out[0][IB-1:0]),
    .coef_i  (sz[1]),
    .add_i   (c_out[1][IB-1:0]),
    .side_i  ({c_out[2][IB-1:0], c_out[3][IB-1:0], |c_err, rdata_q}),
    .valid_o (m1v),
    .acc_o   (a1),
    .side_o  (m1s)
  );

  trra_mac_cell #(.IB(IB), .SB(SB), .SW(M2W)) u_mac2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m1v),
    .acc_i   (a1),
    .coef_i  (sz[2]),
    .add_i   (m1s[M1W-1:M2W]),
    .side_i  (m1s[M2W-1:0]),
    .valid_o (m2v),
    .acc_o   (a2),
    .side_o  (m2s)
  );

  trra_mac_cell #(.IB(IB), .SB(SB), .SW(M3W)) u_mac3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m2v),
    .acc_i   (a2),
    .coef_i  (sz[3]),
    .add_i   (m2s[M2W-1:M3W]),
    .side_i  (m2s[M3W-1:0]),
    .valid_o (m3v),
    .acc_o   (a3),
    .side_o  (m3s)
  );

  assign result_valid_o = m3v;
  assign dest_address_o = 32'(a3);
  assign data_out_o     = m3s[31:0];
  assign range_error_o  = m3s[32];

endmodule

// ----- sv/trra_div_cell.sv -----
// One restoring division step: one quotient bit per cell, registered.
// Used by trra_div_chain; no package dependency.
`timescale 1ns / 1ps

module trra_div_cell #(
  parameter int unsigned IB = 32,
  parameter int unsigned SB = 16,
  parameter int unsigned SW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [SB-1:0] rem_i,
  input  logic [IB-1:0] dq_i,
  input  logic [SW-1:0] side_i,
  input  logic [SB-1:0] divisor_i,
  output logic          valid_o,
  output logic [SB-1:0] rem_o,
  output logic [IB-1:0] dq_o,
  output logic [SW-1:0] side_o
);

  logic [SB:0]   trial;
  logic [SB:0]   diff;
  logic          ge;
  logic [SB-1:0] rem_d;
  logic [IB-1:0] dq_d;

  always_comb begin
    trial = {rem_i, dq_i[IB-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
    rem_d = ge ? diff[SB-1:0] : trial[SB-1:0];
    dq_d  = {dq_i[IB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o  <= rem_d;
    dq_o   <= dq_d;
    side_o <= side_i;
  end

endmodule

// ----- sv/trra_div_chain.sv -----
// Pipelined divider: a row of IB trra_div_cell stages.
// Gives quotient and remainder of an IB-bit index by an SB-bit size.
`timescale 1ns / 1ps

module trra_div_chain #(
  parameter int unsigned IB = 32,
  parameter int unsigned SB = 16,
  parameter int unsigned SW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [IB-1:0] dividend_i,
  input  logic [SW-1:0] side_i,
  input  logic [SB-1:0] divisor_i,
  output logic          valid_o,
  output logic [IB-1:0] quot_o,
  output logic [SB-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          vld  [0:IB];
  logic [SB-1:0] rem  [0:IB];
  logic [IB-1:0] dq   [0:IB];
  logic [SW-1:0] side [0:IB];

  assign vld[0]  = valid_i;
  assign rem[0]  = '0;
  assign dq[0]   = dividend_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < IB; k++) begin : g_cell
    trra_div_cell #(.IB(IB), .SB(SB), .SW(SW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[k]),
      .rem_i     (rem[k]),
      .dq_i      (dq[k]),
      .side_i    (side[k]),
      .divisor_i (divisor_i),
      .valid_o   (vld[k+1]),
      .rem_o     (rem[k+1]),
      .dq_o      (dq[k+1]),
      .side_o    (side[k+1])
    );
  end

  assign valid_o = vld[IB];
  assign quot_o  = dq[IB];
  assign rem_o   = rem[IB];
  assign side_o  = side[IB];

endmodule

// ----- sv/trra_roll_cell.sv -----
// Per-axis roll: add shift, one wrap correction, range check; registered.
// Depends on trra_pkg for the shift width.
`timescale 1ns / 1ps

module trra_roll_cell
  import trra_pkg::*;
#(
  parameter int unsigned CW = 34,
  parameter int unsigned SB = 16
) (
  input  logic              clk_i,
  input  logic [CW-1:0]     coord_i,
  input  logic [SB-1:0]     size_i,
  input  logic [ShiftW-1:0] shift_i,
  output logic [CW-1:0]     coord_o,
  output logic              err_o
);

  logic signed [CW-1:0] sh;
  logic signed [CW-1:0] sz;
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] fixed;
  logic                 err_d;

  always_comb begin
    sh  = CW'(signed'(shift_i));
    sz  = CW'({1'b0, size_i});
    sum = signed'(coord_i) + sh;
    fixed = signed'(coord_i);
    if (shift_i != '0) begin
      if (sum >= sz) begin
        fixed = sum - sz;
      end else if (sum < 0) begin
        fixed = sum + sz;
      end else begin
        fixed = sum;
      end
    end
    err_d = (fixed < 0) || (fixed >= sz);
  end

  always_ff @(posedge clk_i) begin
    coord_o <= fixed;
    err_o   <= err_d;
  end

endmodule

// ----- sv/trra_mac_cell.sv -----
// Address accumulate step: acc * size + coord modulo 2^IB, registered.
// Three of these in a row build the row-major address.
`timescale 1ns / 1ps

module trra_mac_cell #(
  parameter int unsigned IB = 32,
  parameter int unsigned SB = 16,
  parameter int unsigned SW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [IB-1:0] acc_i,
  input  logic [SB-1:0] coef_i,
  input  logic [IB-1:0] add_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [IB-1:0] acc_o,
  output logic [SW-1:0] side_o
);

  logic [IB+SB-1:0] prod;
  logic [IB-1:0]    acc_d;

  always_comb begin
    prod  = {{SB{1'b0}}, acc_i} * {{IB{1'b0}}, coef_i};
    acc_d = prod[IB-1:0] + add_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_o  <= acc_d;
    side_o <= side_i;
  end

endmodule

// ----- sv/trra_checker.sv -----
// Port-level checker for tensor_roll_address_4d_unit, with its bind.
// No package dependency.
`timescale 1ns / 1ps

module trra_checker #(
  parameter int unsigned INDEX_BITS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [31:0] data_word_i,
  input logic        result_valid_o,
  input logic [31:0] data_out_o
);

  localparam int unsigned Lat  = 3*INDEX_BITS + 4;
  localparam int unsigned CntW = $clog2(Lat + 1);

  logic [CntW-1:0] up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= '0;
    end else if (up_q != CntW'(Lat)) begin
      up_q <= up_q + 1'b1;
    end
  end

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_q == CntW'(Lat)) |-> (result_valid_o == $past(start && !busy, Lat)))
    else $error("result strobe does not follow transaction latency");

  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((up_q == CntW'(Lat)) && result_valid_o) |-> (data_out_o == $past(data_word_i, Lat)))
    else $error("data word changed in flight");

  a_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_q < CntW'(Lat)) |-> !result_valid_o)
    else $error("result before any transaction could finish");

endmodule

bind tensor_roll_address_4d_unit trra_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_trra_checker (.*);

// ----- tb/sv/tb_tensor_roll_address_4d_unit.sv -----
// Self-checking testbench for tensor_roll_address_4d_unit.
// Predicts each roll address in a scoreboard class and checks every result transaction.
// Depends on trra_pkg and tensor_roll_address_4d_unit.
`timescale 1ns / 1ps

module tb_tensor_roll_address_4d_unit;
  import trra_pkg::*;

  localparam int unsigned Latency = 3 * 32 + 4;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 4'd9;

  typedef struct packed {
    logic [31:0] dest_address;
    logic [31:0] data_out;
    logic        range_error;
  } roll_result_t;

  class roll_scoreboard;
    logic [15:0]        axis_size[4];
    logic signed [16:0] axis_shift[4];
    roll_result_t       pending[$];
    int                 errors;
    int                 checked;

    function void clear_regs();
      for (int a = 0; a < 4; a++) begin
        axis_size[a]  = 16'd1;
        axis_shift[a] = '0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [16:0] value);
      if (idx <= REG_SIZE3) axis_size[idx[1:0]] = value[15:0];
      else if (idx <= REG_SHIFT3) axis_shift[idx[1:0]] = value;
    endfunction

    function void note_transaction(logic [31:0] index, logic [31:0] word);
      longint      sz[4];
      longint      coord[4];
      longint      rest;
      logic [63:0] addr;
      roll_result_t r;
      r.range_error = 1'b0;
      for (int a = 0; a < 4; a++) sz[a] = (axis_size[a] == 0) ? 1 : longint'(axis_size[a]);
      rest = longint'(index);
      for (int a = 3; a > 0; a--) begin
        coord[a] = rest % sz[a];
        rest     = rest / sz[a];
      end
      coord[0] = rest;
      for (int a = 0; a < 4; a++) begin
        if (axis_shift[a] != 0) begin
          coord[a] += longint'(axis_shift[a]);
          if (coord[a] >= sz[a]) coord[a] -= sz[a];
          else if (coord[a] < 0) coord[a] += sz[a];
        end
        if (coord[a] < 0 || coord[a] >= sz[a]) r.range_error = 1'b1;
      end
      addr = coord[0];
      for (int a = 1; a < 4; a++) addr = addr * sz[a] + coord[a];
      r.dest_address = addr[31:0];
      r.data_out     = word;
      pending.push_back(r);
    endfunction

    function void check_result(roll_result_t got);
      roll_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result transaction addr=%h", got.dest_address);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.dest_address !== exp.dest_address) begin
        $error("dest_address exp %h got %h", exp.dest_address, got.dest_address);
        errors++;
      end
      if (got.data_out !== exp.data_out) begin
        $error("data_out exp %h got %h", exp.data_out, got.data_out);
        errors++;
      end
      if (got.range_error !== exp.range_error) begin
        $error("range_error exp %b got %b", exp.range_error, got.range_error);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_idx_i = '0;
  logic [16:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] element_index_i = '0;
  logic [31:0] data_word_i = '0;
  logic        result_valid_o;
  logic [31:0] dest_address_o;
  logic [31:0] data_out_o;
  logic        range_error_o;

  roll_scoreboard sb = new();
  int sent;

  tensor_roll_address_4d_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy,
    .element_index_i, .data_word_i, .result_valid_o, .dest_address_o,
    .data_out_o, .range_error_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{dest_address_o, data_out_o, range_error_o});
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [16:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] s0, s1, s2, s3, logic [16:0] h0, h1, h2, h3);
    write_cfg(REG_SIZE0, {1'b0, s0});
    write_cfg(REG_SIZE1, {1'b0, s1});
    write_cfg(REG_SIZE2, {1'b0, s2});
    write_cfg(REG_SIZE3, {1'b0, s3});
    write_cfg(REG_SHIFT0, h0);
    write_cfg(REG_SHIFT1, h1);
    write_cfg(REG_SHIFT2, h2);
    write_cfg(REG_SHIFT3, h3);
  endtask

  // Caller is at a falling edge; start is left high for back-to-back transactions.
  task automatic send(logic [31:0] index, logic [31:0] word);
    start           <= 1'b1;
    element_index_i <= index;
    data_word_i     <= word;
    do @(posedge clk_i); while (busy);
    sb.note_transaction(index, word);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    idle_gap(1);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 16'(1);
      1: return 16'hFFFF;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [16:0] rand_shift(logic [15:0] sz);
    int s;
    s = (sz == 0) ? 1 : sz;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'(-65535);
      2: return 17'(65535);
      3: return 17'($urandom);
      4: return 17'(-$urandom_range(1, s));
      default: return 17'($urandom_range(1, s));
    endcase
  endfunction

  function automatic logic [31:0] rand_index();
    longint total;
    total = 1;
    for (int a = 0; a < 4; a++) total *= (sb.axis_size[a] == 0) ? 1 : sb.axis_size[a];
    if ($urandom_range(0, 3) == 0 || total > 64'hFFFF_FFFF) return $urandom;
    return 32'($urandom_range(0, 32'(total - 1)));
  endfunction

  initial begin
    logic [15:0] sz[4];
    sb.clear_regs();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(32'd0, 32'd0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_cfg(RegUnmapped, 17'd2);
    send(32'd7, 32'h0000_0007);
    drain();
    write_all(16'd2, 16'd3, 16'd4, 16'd5, 17'd1, -17'sd1, 17'd0, 17'd2);
    for (int i = 0; i < 10; i++) send(32'(i * 13), $urandom);
    send(32'd119, 32'hA5A5_5A5A);
    send(32'd500, 32'h1234_5678);
    drain();
    write_all(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 17'(65535), 17'(-65535), 17'd5, 17'(-65535));
    send(32'hFFFF_FFFF, 32'h0);
    send(32'h0, 32'hDEAD_BEEF);
    send(32'h8000_0000, 32'h5555_AAAA);
    drain();

    for (int ph = 0; ph < 18; ph++) begin
      for (int a = 0; a < 4; a++) sz[a] = rand_size();
      write_all(sz[0], sz[1], sz[2], sz[3], rand_shift(sz[0]), rand_shift(sz[1]),
                rand_shift(sz[2]), rand_shift(sz[3]));
      for (int i = 0; i < 100; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && i < 100; k++, i++) send(rand_index(), $urandom);
        if (i < 100 && $urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      drain();
    end

    idle_gap(Latency + 10);
    $display("Sent %0d transactions over 21 register settings, %0d results checked.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tensor_roll_address_4d_unit verification clean");
    end else begin
      $display("tensor_roll_address_4d_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tensor_roll_address_4d_unit verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/trra_pkg.sv
sv/trra_div_cell.sv
sv/trra_div_chain.sv
sv/trra_roll_cell.sv
sv/trra_mac_cell.sv
sv/tensor_roll_address_4d_unit.sv
sv/trra_checker.sv
tb/sv/tb_tensor_roll_address_4d_unit.sv
